FILE: rtl/ije_pkg.sv
package ije_pkg;

  localparam int unsigned SEC_W   = 32;
  localparam int unsigned NSEC_W  = 30;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned JIT_W   = 32;
  localparam int unsigned CNT_W   = 32;

  // Seconds to microseconds.
  localparam logic [DELAY_W-1:0] USEC_PER_SEC = 32'd1000000;

  // Nanoseconds to microseconds: multiply by ceil(2^40 / 1000) and keep the
  // bits above 40. The rounding error (224 per 2^40) times any 30-bit
  // magnitude stays below 2^40, so the quotient is exact.
  localparam int unsigned           NS_RECIP_W     = 31;
  localparam logic [NS_RECIP_W-1:0] NS_RECIP       = 31'd1099511628;
  localparam int unsigned           NS_RECIP_SHIFT = 40;
  localparam int unsigned           NS_PROD_W      = NSEC_W + NS_RECIP_W;
  localparam int unsigned           NS_QUOT_W      = NS_PROD_W - NS_RECIP_SHIFT;

  // Smoothing gain of 1/16 as a shift.
  localparam int unsigned JIT_SHIFT = 4;

endpackage

FILE: rtl/ije_if.sv
interface ije_in_if;
  logic                            valid;
  logic                            ready;
  logic [ije_pkg::SEC_W-1:0]       send_sec;
  logic [ije_pkg::NSEC_W-1:0]      send_nsec;
  logic [ije_pkg::SEC_W-1:0]       recv_sec;
  logic [ije_pkg::NSEC_W-1:0]      recv_nsec;

  modport source (output valid, send_sec, send_nsec, recv_sec, recv_nsec, input ready);
  modport sink   (input valid, send_sec, send_nsec, recv_sec, recv_nsec, output ready);
endinterface

interface ije_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ije_pkg::DELAY_W-1:0] delay_us;
  logic [ije_pkg::JIT_W-1:0]          jitter_us;
  logic [ije_pkg::CNT_W-1:0]          packet_count;

  modport source (output valid, delay_us, jitter_us, packet_count, input ready);
  modport sink   (input valid, delay_us, jitter_us, packet_count, output ready);
endinterface

FILE: rtl/ije_delay_calc.sv
module ije_delay_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ije_pkg::SEC_W-1:0]         in_send_sec,
  input  logic [ije_pkg::NSEC_W-1:0]        in_send_nsec,
  input  logic [ije_pkg::SEC_W-1:0]         in_recv_sec,
  input  logic [ije_pkg::NSEC_W-1:0]        in_recv_nsec,
  output logic                              dly_valid,
  input  logic                              dly_ready,
  output logic [ije_pkg::DELAY_W-1:0]       dly_value
);

  localparam int unsigned NSEC_W = ije_pkg::NSEC_W;
  localparam int unsigned QW     = ije_pkg::NS_QUOT_W;

  // Stage 1: timestamp capture.
  logic                          v1_r;
  logic [ije_pkg::SEC_W-1:0]     send_sec_r, recv_sec_r;
  logic [NSEC_W-1:0]             send_nsec_r, recv_nsec_r;
  // Stage 2: products.
  logic                          v2_r;
  logic [ije_pkg::DELAY_W-1:0]   sec_prod_r;
  logic [QW-1:0]                 ns_quot_r;
  logic                          ns_neg_r;
  // Stage 3: delay.
  logic                          v3_r;
  logic [ije_pkg::DELAY_W-1:0]   delay_r;

  logic                          rdy1, rdy2, rdy3;
  logic [ije_pkg::SEC_W-1:0]     sec_diff;
  logic [NSEC_W:0]               ns_diff;
  logic                          ns_neg;
  logic [NSEC_W-1:0]             ns_mag;
  logic [ije_pkg::NS_PROD_W-1:0] ns_prod;
  logic [ije_pkg::DELAY_W-1:0]   sec_prod;
  logic [ije_pkg::DELAY_W-1:0]   ns_term;
  logic [ije_pkg::DELAY_W-1:0]   delay_nxt;

  // A stage takes new data when it is empty or its content moves on.
  assign rdy3     = !v3_r || dly_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    sec_diff = recv_sec_r - send_sec_r;
    sec_prod = sec_diff * ije_pkg::USEC_PER_SEC;
    ns_diff  = {1'b0, recv_nsec_r} - {1'b0, send_nsec_r};
    ns_neg   = ns_diff[NSEC_W];
    ns_mag   = ns_neg ? NSEC_W'(-ns_diff) : ns_diff[NSEC_W-1:0];
    ns_prod  = ije_pkg::NS_PROD_W'(ns_mag) * ije_pkg::NS_PROD_W'(ije_pkg::NS_RECIP);
  end

  // The quotient is a magnitude; truncation toward zero keeps the sign apart.
  always_comb begin
    ns_term   = ije_pkg::DELAY_W'(ns_quot_r);
    if (ns_neg_r) begin
      ns_term = -ns_term;
    end
    delay_nxt = sec_prod_r + ns_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      send_sec_r  <= in_send_sec;
      send_nsec_r <= in_send_nsec;
      recv_sec_r  <= in_recv_sec;
      recv_nsec_r <= in_recv_nsec;
    end
    if (rdy2 && v1_r) begin
      sec_prod_r <= sec_prod;
      ns_quot_r  <= ns_prod[ije_pkg::NS_PROD_W-1:ije_pkg::NS_RECIP_SHIFT];
      ns_neg_r   <= ns_neg;
    end
    if (rdy3 && v2_r) begin
      delay_r <= delay_nxt;
    end
  end

  assign dly_valid = v3_r;
  assign dly_value = delay_r;

endmodule

FILE: rtl/ije_jitter_upd.sv
module ije_jitter_upd (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            dly_valid,
  output logic                            dly_ready,
  input  logic [ije_pkg::DELAY_W-1:0]     dly_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ije_pkg::DELAY_W-1:0]     out_delay,
  output logic [ije_pkg::JIT_W-1:0]       out_jitter,
  output logic [ije_pkg::CNT_W-1:0]       out_count
);

  localparam int unsigned JW = ije_pkg::JIT_W;
  localparam int unsigned SH = ije_pkg::JIT_SHIFT;

  // Stage 4: delay change against the previous message.
  logic                          v4_r;
  logic [ije_pkg::DELAY_W-1:0]   last_delay_r;
  logic [ije_pkg::CNT_W-1:0]     cnt_r;
  logic [ije_pkg::DELAY_W-1:0]   delay4_r;
  logic [ije_pkg::DELAY_W-1:0]   mag_r;
  logic                          first_r;
  logic [ije_pkg::CNT_W-1:0]     cnt4_r;
  // Stage 5: result register; jit_r is also the running estimate.
  logic                          v5_r;
  logic [ije_pkg::DELAY_W-1:0]   delay5_r;
  logic [ije_pkg::CNT_W-1:0]     cnt5_r;
  logic [JW-1:0]                 jit_r;

  logic                          rdy4, rdy5;
  logic [ije_pkg::DELAY_W-1:0]   diff, mag_nxt;
  logic [ije_pkg::CNT_W-1:0]     cnt_nxt;
  logic [JW-1:0]                 err, err_adj, step, jit_nxt;

  assign rdy5      = !v5_r || out_ready;
  assign rdy4      = !v4_r || rdy5;
  assign dly_ready = rdy4;

  always_comb begin
    diff    = dly_value - last_delay_r;
    mag_nxt = diff[ije_pkg::DELAY_W-1] ? -diff : diff;
    cnt_nxt = cnt_r + 1'b1;
  end

  // Signed divide by 16 toward zero: bias negative values before the shift.
  always_comb begin
    err     = JW'(mag_r) - jit_r;
    err_adj = err + (err[JW-1] ? JW'((1 << SH) - 1) : '0);
    step    = {{SH{err_adj[JW-1]}}, err_adj[JW-1:SH]};
    jit_nxt = first_r ? jit_r : jit_r + step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      last_delay_r <= '0;
      cnt_r        <= '0;
      jit_r        <= '0;
    end else begin
      if (rdy4) v4_r <= dly_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy4 && dly_valid) begin
        last_delay_r <= dly_value;
        cnt_r        <= cnt_nxt;
      end
      if (rdy5 && v4_r) begin
        jit_r <= jit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && dly_valid) begin
      delay4_r <= dly_value;
      mag_r    <= mag_nxt;
      first_r  <= (cnt_r == '0);
      cnt4_r   <= cnt_nxt;
    end
    if (rdy5 && v4_r) begin
      delay5_r <= delay4_r;
      cnt5_r   <= cnt4_r;
    end
  end

  assign out_valid  = v5_r;
  assign out_delay  = delay5_r;
  assign out_jitter = jit_r;
  assign out_count  = cnt5_r;

endmodule

FILE: rtl/interarrival_jitter_estimator.sv
// Interarrival jitter estimator.
// in_if carries one received message per transfer: send and receive
// timestamps as seconds plus nanoseconds. out_if returns one result per
// message: the one-way delay in microseconds, the smoothed jitter after
// that message (gain 1/16), and the running message count.
// Throughput: one message per cycle while out_if.ready stays high. The
// five stages are input capture, the two constant multiplies, the delay
// sum, the delay change against the previous message, and the jitter
// update in the result register.
// The jitter recurrence closes within the last stage only.
// Reset (rst_n low at a clock edge) empties the pipeline and clears the
// previous delay, the jitter and the count; the next message is treated as
// the first and leaves the jitter unchanged. The same holds after the count
// wraps to zero.
// When the receiver holds out_if.ready low, the result stays put and the
// stages behind it keep filling; in_if.ready falls only when all are full.
module interarrival_jitter_estimator (
  input  logic       clk,
  input  logic       rst_n,
  ije_in_if.sink     in_if,
  ije_out_if.source  out_if
);

  logic                          dly_valid;
  logic                          dly_ready;
  logic [ije_pkg::DELAY_W-1:0]   dly_value;
  logic [ije_pkg::DELAY_W-1:0]   out_delay;

  ije_delay_calc u_delay (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_send_sec  (in_if.send_sec),
    .in_send_nsec (in_if.send_nsec),
    .in_recv_sec  (in_if.recv_sec),
    .in_recv_nsec (in_if.recv_nsec),
    .dly_valid    (dly_valid),
    .dly_ready    (dly_ready),
    .dly_value    (dly_value)
  );

  ije_jitter_upd u_jitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .dly_valid  (dly_valid),
    .dly_ready  (dly_ready),
    .dly_value  (dly_value),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_delay  (out_delay),
    .out_jitter (out_if.jitter_us),
    .out_count  (out_if.packet_count)
  );

  assign out_if.delay_us = signed'(out_delay);

endmodule

FILE: rtl/ije_checker.sv
module ije_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ije_pkg::DELAY_W-1:0] out_delay_us,
  input logic [ije_pkg::JIT_W-1:0]         out_jitter_us,
  input logic [ije_pkg::CNT_W-1:0]         out_packet_count
);

  logic                      out_xfer;
  logic                      seen_r;
  logic [ije_pkg::CNT_W-1:0] last_cnt_r;
  logic [ije_pkg::JIT_W-1:0] last_jit_r;

  assign out_xfer = out_valid && out_ready;

  // Remembers the last delivered count and jitter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      last_cnt_r <= '0;
      last_jit_r <= '0;
    end else if (out_xfer) begin
      seen_r     <= 1'b1;
      last_cnt_r <= out_packet_count;
      last_jit_r <= out_jitter_us;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_delay_us) &&
      $stable(out_jitter_us) && $stable(out_packet_count))
    else $error("stalled result changed");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_r |-> out_packet_count == last_cnt_r + 1'b1)
    else $error("message count skipped or repeated");

  a_first_keeps_jitter: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_packet_count == 32'd1 |-> out_jitter_us == last_jit_r)
    else $error("first message changed the jitter");

endmodule

bind interarrival_jitter_estimator ije_checker u_ije_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_delay_us     (out_if.delay_us),
  .out_jitter_us    (out_if.jitter_us),
  .out_packet_count (out_if.packet_count)
);

FILE: test/interarrival_jitter_estimator_test.sv
`timescale 1ns / 100ps

module interarrival_jitter_estimator_test;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam longint      NS_PER_SEC     = 1000000000;

  typedef struct packed {
    logic [ije_pkg::SEC_W-1:0]  send_sec;
    logic [ije_pkg::NSEC_W-1:0] send_nsec;
    logic [ije_pkg::SEC_W-1:0]  recv_sec;
    logic [ije_pkg::NSEC_W-1:0] recv_nsec;
  } message_t;

  typedef struct packed {
    logic [ije_pkg::DELAY_W-1:0] delay_us;
    logic [ije_pkg::JIT_W-1:0]   jitter_us;
    logic [ije_pkg::CNT_W-1:0]   packet_count;
  } delay_report_t;

  logic clk;
  logic rst_n;

  ije_in_if  in_ch ();
  ije_out_if out_ch ();

  interarrival_jitter_estimator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Shadow state of the estimator.
  logic [ije_pkg::DELAY_W-1:0] last_delay;
  logic [ije_pkg::JIT_W-1:0]   jitter_est;
  logic [ije_pkg::CNT_W-1:0]   msg_count;

  delay_report_t pending_reports[$];
  int unsigned   error_count;
  int unsigned   quiet_cycles;
  bit            idling;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic delay_report_t estimate_report(message_t m);
    logic [31:0]   sec_part;
    int            ns_diff;
    int            ns_quot;
    logic [31:0]   change;
    logic [31:0]   change_mag;
    int            gap;
    int            gap_quot;
    delay_report_t r;
    sec_part = (m.recv_sec - m.send_sec) * ije_pkg::USEC_PER_SEC;
    ns_diff  = int'({2'b00, m.recv_nsec}) - int'({2'b00, m.send_nsec});
    // Kept in a signed variable so the division truncates toward zero.
    ns_quot    = ns_diff / 1000;
    r.delay_us = sec_part + ns_quot;
    if (msg_count != '0) begin
      change     = r.delay_us - last_delay;
      change_mag = change[31] ? (32'd0 - change) : change;
      gap        = change_mag - jitter_est;
      gap_quot   = gap / 16;
      jitter_est = jitter_est + gap_quot;
    end
    last_delay     = r.delay_us;
    msg_count      = msg_count + 1'b1;
    r.jitter_us    = jitter_est;
    r.packet_count = msg_count;
    return r;
  endfunction

  task automatic log_failure(input string detail);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t ns: %s", $realtime, detail);
    end
  endtask

  always @(posedge clk) begin : result_check
    message_t      seen;
    delay_report_t want;
    delay_report_t got;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        seen.send_sec  = in_ch.send_sec;
        seen.send_nsec = in_ch.send_nsec;
        seen.recv_sec  = in_ch.recv_sec;
        seen.recv_nsec = in_ch.recv_nsec;
        pending_reports.push_back(estimate_report(seen));
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles   = 0;
        got.delay_us     = out_ch.delay_us;
        got.jitter_us    = out_ch.jitter_us;
        got.packet_count = out_ch.packet_count;
        if (pending_reports.size() == 0) begin
          log_failure($sformatf("unexpected result, delay_us %0d count %0d",
                                $signed(got.delay_us), got.packet_count));
        end else begin
          want = pending_reports.pop_front();
          if (got.delay_us !== want.delay_us)
            log_failure($sformatf("message %0d: delay_us expected %0d, got %0d",
                                  want.packet_count, $signed(want.delay_us),
                                  $signed(got.delay_us)));
          if (got.jitter_us !== want.jitter_us)
            log_failure($sformatf("message %0d: jitter_us expected %0d, got %0d",
                                  want.packet_count, want.jitter_us, got.jitter_us));
          if (got.packet_count !== want.packet_count)
            log_failure($sformatf("packet_count expected %0d, got %0d",
                                  want.packet_count, got.packet_count));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side back-pressure.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Returns at the rising edge where the transfer happens.
  task automatic send_message(input message_t m);
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.send_sec  <= m.send_sec;
    in_ch.send_nsec <= m.send_nsec;
    in_ch.recv_sec  <= m.recv_sec;
    in_ch.recv_nsec <= m.recv_nsec;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_fields(input logic [ije_pkg::SEC_W-1:0]  ssec,
                             input logic [ije_pkg::NSEC_W-1:0] snsec,
                             input logic [ije_pkg::SEC_W-1:0]  rsec,
                             input logic [ije_pkg::NSEC_W-1:0] rnsec);
    message_t m;
    m.send_sec  = ssec;
    m.send_nsec = snsec;
    m.recv_sec  = rsec;
    m.recv_nsec = rnsec;
    send_message(m);
  endtask

  // The first message after reset sets the delay but leaves the jitter at zero.
  task automatic test_first_message();
    send_fields(32'd0, 30'd0, 32'd0, 30'd0);
    send_fields(32'd100, 30'd0, 32'd100, 30'd250000);
  endtask

  task automatic test_field_extremes();
    send_fields('1, 30'd0, 32'd0, 30'd0);
    send_fields(32'd0, 30'd0, '1, 30'd0);
    send_fields(32'd7, '1, 32'd7, 30'd0);
    send_fields(32'd7, 30'd0, 32'd7, '1);
    send_fields(32'd9, 30'd999999999, 32'd9, 30'd999999999);
    // Sub-microsecond remainders truncate toward zero in both directions.
    send_fields(32'd5, 30'd0, 32'd5, 30'd1999);
    send_fields(32'd5, 30'd1999, 32'd5, 30'd0);
    send_fields('1, '1, '1, '1);
  endtask

  task automatic test_delay_wrap();
    send_fields(32'd0, 30'd0, 32'd2148, 30'd0);
    send_fields(32'd1000, 30'd0, 32'd5295, 30'd0);
    send_fields(32'd0, 30'd0, 32'd0, 30'd0);
    // A delay of exactly -2^31 after zero: the change has magnitude 2^31.
    send_fields(32'd0, 30'd0, 32'd2147, 30'd483648000);
    send_fields(32'd0, 30'd0, 32'd0, 30'd0);
    // Repeated delays let the estimate decay.
    repeat (4) send_fields(32'd50, 30'd0, 32'd50, 30'd0);
  endtask

  task automatic test_random_traffic(input int unsigned n_msgs);
    message_t    m;
    int unsigned base_us;
    int unsigned spread_us;
    int unsigned kind;
    longint      t_ns;
    base_us   = $urandom_range(0, 2000000);
    spread_us = $urandom_range(1, 50000);
    repeat (n_msgs) begin
      kind        = $urandom_range(0, 9);
      m.send_sec  = $urandom();
      m.send_nsec = ije_pkg::NSEC_W'($urandom_range(0, 999999999));
      if (kind < 6) begin
        // Plausible traffic: a steady delay plus a bounded variation.
        t_ns = longint'(m.send_nsec)
             + longint'(base_us + $urandom_range(0, spread_us)) * 1000
             + longint'($urandom_range(0, 999));
        m.recv_sec  = m.send_sec + ije_pkg::SEC_W'(t_ns / NS_PER_SEC);
        m.recv_nsec = ije_pkg::NSEC_W'(t_ns % NS_PER_SEC);
      end else if (kind < 8) begin
        m.send_nsec = ije_pkg::NSEC_W'($urandom());
        m.recv_sec  = $urandom();
        m.recv_nsec = ije_pkg::NSEC_W'($urandom());
      end else begin
        m.recv_sec  = m.send_sec + ije_pkg::SEC_W'($urandom_range(0, 4))
                    - ije_pkg::SEC_W'(2);
        m.recv_nsec = ije_pkg::NSEC_W'($urandom_range(0, 999999999));
      end
      send_message(m);
    end
  endtask

  // Closing stretch with both sides always ready.
  task automatic test_back_to_back_tail();
    idling = 1'b0;
    test_random_traffic(200);
  endtask

  initial begin
    rst_n           = 1'b0;
    idling          = 1'b1;
    error_count     = 0;
    quiet_cycles    = 0;
    last_delay      = '0;
    jitter_est      = '0;
    msg_count       = '0;
    in_ch.valid     = 1'b0;
    in_ch.send_sec  = '0;
    in_ch.send_nsec = '0;
    in_ch.recv_sec  = '0;
    in_ch.recv_nsec = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_first_message();
    test_field_extremes();
    test_delay_wrap();
    test_random_traffic(300);
    idling = 1'b0;
    test_random_traffic(250);
    idling = 1'b1;
    test_random_traffic(350);
    test_back_to_back_tail();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
